FILE: rtl/core/base58_decoder_assert.svh
// Assertion macros used by the base58 decoder checker.
`ifndef BASE58_DECODER_ASSERT_SVH
`define BASE58_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define B58D_ASSERT_SAME(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define B58D_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/core/b58d_pkg.sv
// Shared types, constants and the alphabet lookup of the base58 decoder.
package b58d_pkg;

	localparam int unsigned MAX_BYTES_DEF = 64;
	localparam int unsigned BASE          = 58;

	localparam int unsigned LZ_W       = 7;
	localparam int unsigned TOT_W      = 8;
	localparam int unsigned OUT_LIM_W  = 7;
	localparam int unsigned CARRY_W    = 6;
	localparam int unsigned SUM_W      = 14;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [7:0]           NO_DIGIT      = 8'hFF;
	localparam logic [7:0]           ZERO_CHAR     = 8'h31;
	localparam logic [LZ_W-1:0]      LZ_MAX        = 7'd127;
	localparam logic [OUT_LIM_W-1:0] OUT_LIMIT_RST = 7'd64;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXACT_LENGTH = 2'd1;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;
	localparam logic [1:0] ST_MISMATCH = 2'd3;

	localparam logic [8*BASE-1:0] ALPHABET =
		"123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic [1:0] status;
	} out_item_t;

	// digit value of a character, NO_DIGIT when it is not in the alphabet
	function automatic logic [7:0] digit_of(input logic [7:0] c);
		logic [7:0] d;
		d = NO_DIGIT;
		for (int i = 0; i < BASE; i++) begin
			if (ALPHABET[8*(BASE-1-i) +: 8] == c) begin
				d = 8'(i);
			end
		end
		return d;
	endfunction

endpackage

FILE: rtl/core/b58d_mac.sv
// Byte multiply-accumulate unit: {carry, byte} = byte * 58 + carry.
module b58d_mac (
	input  logic [7:0]                    byte_in,
	input  logic [b58d_pkg::CARRY_W-1:0]  carry_in,
	output logic [7:0]                    byte_out,
	output logic [b58d_pkg::CARRY_W-1:0]  carry_out
);

	logic [b58d_pkg::SUM_W-1:0] prod;
	logic [b58d_pkg::SUM_W-1:0] sum;

	// largest sum is 255 * 58 + 57, so the carry never exceeds 57
	assign prod      = b58d_pkg::SUM_W'(byte_in) * b58d_pkg::SUM_W'(b58d_pkg::BASE);
	assign sum       = prod + b58d_pkg::SUM_W'(carry_in);
	assign byte_out  = sum[7:0];
	assign carry_out = sum[8 +: b58d_pkg::CARRY_W];

endmodule

FILE: rtl/core/base58_decoder.sv
// Base58 (Bitcoin alphabet) decoder: one character per request in, decoded bytes out.
// Each character request is taken when in_ready is high. A leading '1' only raises the
// leading-zero count. Any other valid character starts a carry pass that multiplies the
// accumulator by 58 and adds the digit, one accumulator byte per cycle through a single
// byte multiply-accumulate unit against the accumulator memory (one read, one write per
// cycle). After the character marked last, the length checks follow, then one result per
// leading zero byte and, per accumulator byte, a memory read and then an output load; an
// error gives a single result with data_byte zero. A finished result waits in the output
// register while the next text is already being accepted. The accumulator is never
// cleared: bytes past the significant count read as zero.
module base58_decoder #(
	parameter int unsigned MAX_BYTES = b58d_pkg::MAX_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  b58d_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output b58d_pkg::out_item_t              out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [b58d_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [b58d_pkg::OUT_LIM_W-1:0]   cfg_data
);

	localparam int unsigned AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int unsigned CW = $clog2(MAX_BYTES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FOLD,
		S_CHECK,
		S_EMIT_ZERO,
		S_EMIT_RD,
		S_EMIT_WR
	} state_t;

	state_t                               state_q;
	logic                                 last_q;
	logic [CW-1:0]                        j_q;
	logic [CW-1:0]                        used_q;
	logic [CW-1:0]                        k_q;
	logic [b58d_pkg::CARRY_W-1:0]         carry_q;
	logic [b58d_pkg::LZ_W-1:0]            lz_q;
	logic [b58d_pkg::LZ_W-1:0]            zc_q;
	logic                                 run_q;
	logic                                 bad_q;
	logic                                 ovf_q;
	logic                                 out_valid_q;
	b58d_pkg::out_item_t                  out_q;
	logic [b58d_pkg::OUT_LIM_W-1:0]       out_limit_q;
	logic                                 exact_q;

	logic [7:0]                           mem [MAX_BYTES];
	logic [7:0]                           rdata_q;

	logic                                 in_acc;
	logic [7:0]                           dig;
	logic                                 is_zero_char;
	logic                                 fold_start;
	logic [7:0]                           byte_cur;
	logic [7:0]                           mac_byte;
	logic [b58d_pkg::CARRY_W-1:0]         mac_carry;
	logic [CW-1:0]                        j_inc;
	logic                                 fold_done;
	logic                                 slot_free;
	logic                                 load_out;
	logic [b58d_pkg::TOT_W-1:0]           total;
	logic [1:0]                           status_sel;
	logic                                 rd_en;
	logic [AW-1:0]                        rd_addr;
	logic                                 wr_en;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign in_acc       = in_valid && in_ready;
	assign dig          = b58d_pkg::digit_of(in_data.char_code);
	assign is_zero_char = run_q && (in_data.char_code == b58d_pkg::ZERO_CHAR);
	assign fold_start   = !is_zero_char && !bad_q && (dig != b58d_pkg::NO_DIGIT);

	// bytes beyond the significant count are zero
	assign byte_cur  = (j_q < used_q) ? rdata_q : 8'h00;
	assign j_inc     = j_q + CW'(1);
	assign fold_done = ((j_q >= used_q) && (carry_q == '0)) || (j_q == CW'(MAX_BYTES));
	assign slot_free = !out_valid_q || out_ready;

	// a result goes into the output register this cycle
	assign load_out = slot_free && (((state_q == S_CHECK) && (status_sel != b58d_pkg::ST_OK))
			|| (state_q == S_EMIT_ZERO) || (state_q == S_EMIT_WR));

	b58d_mac u_mac (
		.byte_in   (byte_cur),
		.carry_in  (carry_q),
		.byte_out  (mac_byte),
		.carry_out (mac_carry)
	);

	assign total = b58d_pkg::TOT_W'(lz_q) + b58d_pkg::TOT_W'(used_q);

	always_comb begin
		if (bad_q) begin
			status_sel = b58d_pkg::ST_BAD_CHAR;
		end else if (ovf_q || (total > b58d_pkg::TOT_W'(MAX_BYTES))
				|| (total > b58d_pkg::TOT_W'(out_limit_q))) begin
			status_sel = b58d_pkg::ST_TOO_LONG;
		end else if (exact_q && (total != b58d_pkg::TOT_W'(out_limit_q))) begin
			status_sel = b58d_pkg::ST_MISMATCH;
		end else begin
			status_sel = b58d_pkg::ST_OK;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				rd_en = in_acc && fold_start;
			end
			S_FOLD: begin
				rd_en   = !fold_done && (j_inc != CW'(MAX_BYTES));
				rd_addr = j_inc[AW-1:0];
			end
			S_EMIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(k_q - CW'(1));
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign wr_en = (state_q == S_FOLD) && !fold_done;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[j_q[AW-1:0]] <= mac_byte;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= b58d_pkg::OUT_LIMIT_RST;
			exact_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				b58d_pkg::REG_OUT_LIMIT:    out_limit_q <= cfg_data;
				b58d_pkg::REG_EXACT_LENGTH: exact_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			j_q         <= '0;
			used_q      <= '0;
			k_q         <= '0;
			carry_q     <= '0;
			lz_q        <= '0;
			zc_q        <= '0;
			run_q       <= 1'b1;
			bad_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						last_q <= in_data.last_char;
						if (is_zero_char) begin
							if (lz_q != b58d_pkg::LZ_MAX) begin
								lz_q <= lz_q + b58d_pkg::LZ_W'(1);
							end
							if (in_data.last_char) begin
								state_q <= S_CHECK;
							end
						end else begin
							run_q <= 1'b0;
							if (!bad_q && (dig == b58d_pkg::NO_DIGIT)) begin
								bad_q <= 1'b1;
							end
							if (fold_start) begin
								carry_q <= dig[b58d_pkg::CARRY_W-1:0];
								j_q     <= '0;
								state_q <= S_FOLD;
							end else if (in_data.last_char) begin
								state_q <= S_CHECK;
							end
						end
					end
				end
				S_FOLD: begin
					if (fold_done) begin
						// carry left over past the top byte
						if (carry_q != '0) begin
							ovf_q <= 1'b1;
						end
						state_q <= last_q ? S_CHECK : S_IDLE;
					end else begin
						carry_q <= mac_carry;
						j_q     <= j_inc;
						if (j_q >= used_q) begin
							used_q <= j_inc;
						end
					end
				end
				S_CHECK: begin
					if (status_sel != b58d_pkg::ST_OK) begin
						if (slot_free) begin
							out_q.data_byte <= 8'h00;
							out_q.last_byte <= 1'b1;
							out_q.status    <= status_sel;
							used_q          <= '0;
							lz_q            <= '0;
							run_q           <= 1'b1;
							bad_q           <= 1'b0;
							ovf_q           <= 1'b0;
							state_q         <= S_IDLE;
						end
					end else if (lz_q != '0) begin
						zc_q    <= lz_q;
						state_q <= S_EMIT_ZERO;
					end else if (used_q != '0) begin
						k_q     <= used_q;
						state_q <= S_EMIT_RD;
					end else begin
						run_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_EMIT_ZERO: begin
					if (slot_free) begin
						out_q.data_byte <= 8'h00;
						out_q.last_byte <= (zc_q == b58d_pkg::LZ_W'(1)) && (used_q == '0);
						out_q.status    <= b58d_pkg::ST_OK;
						zc_q            <= zc_q - b58d_pkg::LZ_W'(1);
						if (zc_q == b58d_pkg::LZ_W'(1)) begin
							if (used_q == '0) begin
								lz_q    <= '0;
								run_q   <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								k_q     <= used_q;
								state_q <= S_EMIT_RD;
							end
						end
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (slot_free) begin
						out_q.data_byte <= rdata_q;
						out_q.last_byte <= (k_q == CW'(1));
						out_q.status    <= b58d_pkg::ST_OK;
						k_q             <= k_q - CW'(1);
						if (k_q == CW'(1)) begin
							used_q  <= '0;
							lz_q    <= '0;
							run_q   <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/b58d_checker.sv
// Port-level checker for the base58 decoder, bound to the top level.
`include "base58_decoder_assert.svh"

module b58d_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  b58d_pkg::in_item_t    in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  b58d_pkg::out_item_t   out_data
);

	// a stalled result request holds
	`B58D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

	// an error result is a single zero byte that closes the text
	`B58D_ASSERT_SAME(a_err_form, out_valid && (out_data.status != b58d_pkg::ST_OK), out_data.last_byte && (out_data.data_byte == 8'h00), "malformed error result")

	// the final character always leads to checking, never straight to idle
	`B58D_ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_data.last_char, !in_ready, "ready right after final character")

endmodule

bind base58_decoder b58d_checker u_b58d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
